// ===== hdl/bpc_pkg.sv =====
// Shared types, operand codes and the compensation microprogram.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int RegCount = 8;
  localparam int RegAw = 3;
  localparam int PcW = 6;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_ASR = 4'd2,
    OP_SHL = 4'd3,
    OP_MUL = 4'd4,
    OP_DIV = 4'd5,
    OP_CHK = 4'd6,
    OP_FIN = 4'd7
  } op_t;

  // Codes below eight name scratch registers; the rest are fixed operands.
  typedef enum logic [4:0] {
    OPD_R0 = 5'd0, OPD_R1 = 5'd1, OPD_R2 = 5'd2, OPD_R3 = 5'd3,
    OPD_R4 = 5'd4, OPD_R5 = 5'd5, OPD_R6 = 5'd6, OPD_R7 = 5'd7,
    OPD_T1 = 5'd8, OPD_T2 = 5'd9, OPD_T3 = 5'd10,
    OPD_P1 = 5'd11, OPD_P2 = 5'd12, OPD_P3 = 5'd13, OPD_P4 = 5'd14,
    OPD_P5 = 5'd15, OPD_P6 = 5'd16, OPD_P7 = 5'd17, OPD_P8 = 5'd18,
    OPD_P9 = 5'd19,
    OPD_ADCT = 5'd20, OPD_ADCP = 5'd21,
    OPD_K5 = 5'd22, OPD_K128 = 5'd23, OPD_K128000 = 5'd24,
    OPD_K3125 = 5'd25, OPD_K1048576 = 5'd26, OPD_K2P47 = 5'd27,
    OPD_ZERO = 5'd28
  } opd_t;

  typedef struct packed {
    op_t              op;
    logic [RegAw-1:0] dst;
    opd_t             sa;
    opd_t             sb;
    logic [5:0]       sh;
  } instr_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    instr_t instr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic a_zero;
    logic out_free;
  } dp_status_t;

  localparam logic [PcW-1:0] FinPc = 6'd48;

  function automatic instr_t mk(op_t op, logic [RegAw-1:0] dst, opd_t sa, opd_t sb,
                                logic [5:0] sh);
    instr_t i;
    i.op = op;
    i.dst = dst;
    i.sa = sa;
    i.sb = sb;
    i.sh = sh;
    return i;
  endfunction

  function automatic instr_t program_rom(logic [PcW-1:0] pc);
    instr_t i;
    case (pc)
      // Temperature.
      6'd0:  i = mk(OP_ASR, 3'd0, OPD_ADCT, OPD_ZERO, 6'd3);
      6'd1:  i = mk(OP_SHL, 3'd1, OPD_T1, OPD_ZERO, 6'd1);
      6'd2:  i = mk(OP_SUB, 3'd0, OPD_R0, OPD_R1, 6'd0);
      6'd3:  i = mk(OP_MUL, 3'd0, OPD_R0, OPD_T2, 6'd0);
      6'd4:  i = mk(OP_ASR, 3'd0, OPD_R0, OPD_ZERO, 6'd11);
      6'd5:  i = mk(OP_ASR, 3'd1, OPD_ADCT, OPD_ZERO, 6'd4);
      6'd6:  i = mk(OP_SUB, 3'd1, OPD_R1, OPD_T1, 6'd0);
      6'd7:  i = mk(OP_MUL, 3'd1, OPD_R1, OPD_R1, 6'd0);
      6'd8:  i = mk(OP_ASR, 3'd1, OPD_R1, OPD_ZERO, 6'd12);
      6'd9:  i = mk(OP_MUL, 3'd1, OPD_R1, OPD_T3, 6'd0);
      6'd10: i = mk(OP_ASR, 3'd1, OPD_R1, OPD_ZERO, 6'd14);
      6'd11: i = mk(OP_ADD, 3'd0, OPD_R0, OPD_R1, 6'd0);
      6'd12: i = mk(OP_MUL, 3'd1, OPD_R0, OPD_K5, 6'd0);
      6'd13: i = mk(OP_ADD, 3'd1, OPD_R1, OPD_K128, 6'd0);
      6'd14: i = mk(OP_ASR, 3'd1, OPD_R1, OPD_ZERO, 6'd8);
      // Pressure divisor and offset.
      6'd15: i = mk(OP_SUB, 3'd2, OPD_R0, OPD_K128000, 6'd0);
      6'd16: i = mk(OP_MUL, 3'd3, OPD_R2, OPD_R2, 6'd0);
      6'd17: i = mk(OP_MUL, 3'd4, OPD_R3, OPD_P6, 6'd0);
      6'd18: i = mk(OP_MUL, 3'd5, OPD_R2, OPD_P5, 6'd0);
      6'd19: i = mk(OP_SHL, 3'd5, OPD_R5, OPD_ZERO, 6'd17);
      6'd20: i = mk(OP_ADD, 3'd4, OPD_R4, OPD_R5, 6'd0);
      6'd21: i = mk(OP_SHL, 3'd5, OPD_P4, OPD_ZERO, 6'd35);
      6'd22: i = mk(OP_ADD, 3'd4, OPD_R4, OPD_R5, 6'd0);
      6'd23: i = mk(OP_MUL, 3'd3, OPD_R3, OPD_P3, 6'd0);
      6'd24: i = mk(OP_ASR, 3'd3, OPD_R3, OPD_ZERO, 6'd8);
      6'd25: i = mk(OP_MUL, 3'd5, OPD_R2, OPD_P2, 6'd0);
      6'd26: i = mk(OP_SHL, 3'd5, OPD_R5, OPD_ZERO, 6'd12);
      6'd27: i = mk(OP_ADD, 3'd3, OPD_R3, OPD_R5, 6'd0);
      6'd28: i = mk(OP_ADD, 3'd3, OPD_R3, OPD_K2P47, 6'd0);
      6'd29: i = mk(OP_MUL, 3'd3, OPD_R3, OPD_P1, 6'd0);
      6'd30: i = mk(OP_ASR, 3'd3, OPD_R3, OPD_ZERO, 6'd33);
      6'd31: i = mk(OP_CHK, 3'd0, OPD_R3, OPD_ZERO, 6'd0);
      // Pressure.
      6'd32: i = mk(OP_SUB, 3'd5, OPD_K1048576, OPD_ADCP, 6'd0);
      6'd33: i = mk(OP_SHL, 3'd5, OPD_R5, OPD_ZERO, 6'd31);
      6'd34: i = mk(OP_SUB, 3'd5, OPD_R5, OPD_R4, 6'd0);
      6'd35: i = mk(OP_MUL, 3'd5, OPD_R5, OPD_K3125, 6'd0);
      6'd36: i = mk(OP_DIV, 3'd5, OPD_R5, OPD_R3, 6'd0);
      6'd37: i = mk(OP_ASR, 3'd6, OPD_R5, OPD_ZERO, 6'd13);
      6'd38: i = mk(OP_MUL, 3'd6, OPD_R6, OPD_R6, 6'd0);
      6'd39: i = mk(OP_MUL, 3'd6, OPD_R6, OPD_P9, 6'd0);
      6'd40: i = mk(OP_ASR, 3'd6, OPD_R6, OPD_ZERO, 6'd25);
      6'd41: i = mk(OP_MUL, 3'd7, OPD_R5, OPD_P8, 6'd0);
      6'd42: i = mk(OP_ASR, 3'd7, OPD_R7, OPD_ZERO, 6'd19);
      6'd43: i = mk(OP_ADD, 3'd5, OPD_R5, OPD_R6, 6'd0);
      6'd44: i = mk(OP_ADD, 3'd5, OPD_R5, OPD_R7, 6'd0);
      6'd45: i = mk(OP_ASR, 3'd5, OPD_R5, OPD_ZERO, 6'd8);
      6'd46: i = mk(OP_SHL, 3'd6, OPD_P7, OPD_ZERO, 6'd4);
      6'd47: i = mk(OP_ADD, 3'd5, OPD_R5, OPD_R6, 6'd0);
      default: i = mk(OP_FIN, 3'd0, OPD_R1, OPD_R5, 6'd0);
    endcase
    return i;
  endfunction

endpackage

// ===== hdl/bpc_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module bpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/bpc_ctrl.sv =====
// Microprogram sequencer that steps the datapath through the compensation.
`timescale 1ns / 1ps
module bpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bpc_pkg::dp_status_t   sts,
  output bpc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [bpc_pkg::PcW-1:0] pc_r, pc_nxt;
  bpc_pkg::instr_t instr;
  logic in_xfer;

  assign instr = bpc_pkg::program_rom(pc_r);
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer = in_valid && !in_stall;

  assign cmd.load = in_xfer;
  assign cmd.exec = (state_r == ST_EXEC);
  assign cmd.instr = instr;

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FETCH;
          pc_nxt = '0;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (instr.op)
          bpc_pkg::OP_MUL, bpc_pkg::OP_DIV: begin
            state_nxt = ST_WAIT;
          end
          bpc_pkg::OP_CHK: begin
            state_nxt = ST_FETCH;
            pc_nxt = sts.a_zero ? bpc_pkg::FinPc : pc_r + 6'd1;
          end
          bpc_pkg::OP_FIN: begin
            if (sts.out_free) begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_FETCH;
            pc_nxt = pc_r + 6'd1;
          end
        endcase
      end
      ST_WAIT: begin
        if (sts.unit_done) begin
          state_nxt = ST_FETCH;
          pc_nxt = pc_r + 6'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_FETCH)
    else $error("accepted item did not start the program");

  a_wait_on_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> (instr.op == bpc_pkg::OP_MUL || instr.op == bpc_pkg::OP_DIV))
    else $error("waiting on a unit for a single-cycle instruction");

endmodule

// ===== hdl/bpc_datapath.sv =====
// Datapath: calibration registers, scratch RAM, ALU, multiplier and divider.
`timescale 1ns / 1ps
module bpc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpc_pkg::ctrl_cmd_t   cmd,
  output bpc_pkg::dp_status_t  sts,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [19:0]          in_raw_temperature,
  input  logic [19:0]          in_raw_pressure,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_temperature_centi,
  output logic [31:0]          out_pressure_q24_8,
  output logic                 out_pressure_held
);

  localparam logic [1:0] CfgA = 2'd0;
  localparam logic [1:0] CfgB = 2'd1;
  localparam logic [1:0] CfgC = 2'd2;

  logic [63:0] calib_a_r, calib_b_r, calib_c_r;
  logic [19:0] adct_r, adcp_r;
  logic [31:0] last_r;
  logic held_r;
  logic out_valid_r;
  logic [31:0] out_temp_r, out_pres_r;
  logic out_held_r;

  logic [63:0] rdata_a, rdata_b, opa, opb, alu_res, wdata;
  logic we;
  logic exec_simple, mul_start, div_start, fin_go;
  logic [31:0] pres_sat;

  // Multiplier: 64x64 modulo 2^64 from three 32x32 partial products.
  logic [63:0] ma_r, mb_r, acc_r;
  logic [1:0] mcnt_r;
  logic mul_busy_r, mul_done;
  logic [31:0] mpa, mpb, mul_hi_sum;
  logic [63:0] mprod, mul_result;

  // Divider: restoring, one quotient bit per cycle on magnitudes.
  logic [63:0] dv_rem_r, dv_q_r, dv_d_r;
  logic [5:0] dv_cnt_r;
  logic dv_neg_r, div_busy_r, div_done;
  logic [64:0] dv_trial, dv_diff;
  logic dv_ge;
  logic [63:0] dv_qn, div_result;

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] operand(bpc_pkg::opd_t code, logic [63:0] rd,
                                          logic [63:0] ca, logic [63:0] cb,
                                          logic [63:0] cc, logic [19:0] at,
                                          logic [19:0] ap);
    logic [63:0] v;
    case (code)
      bpc_pkg::OPD_T1:       v = {48'd0, ca[15:0]};
      bpc_pkg::OPD_T2:       v = sx16(ca[31:16]);
      bpc_pkg::OPD_T3:       v = sx16(ca[47:32]);
      bpc_pkg::OPD_P1:       v = {48'd0, ca[63:48]};
      bpc_pkg::OPD_P2:       v = sx16(cb[15:0]);
      bpc_pkg::OPD_P3:       v = sx16(cb[31:16]);
      bpc_pkg::OPD_P4:       v = sx16(cb[47:32]);
      bpc_pkg::OPD_P5:       v = sx16(cb[63:48]);
      bpc_pkg::OPD_P6:       v = sx16(cc[15:0]);
      bpc_pkg::OPD_P7:       v = sx16(cc[31:16]);
      bpc_pkg::OPD_P8:       v = sx16(cc[47:32]);
      bpc_pkg::OPD_P9:       v = sx16(cc[63:48]);
      bpc_pkg::OPD_ADCT:     v = {44'd0, at};
      bpc_pkg::OPD_ADCP:     v = {44'd0, ap};
      bpc_pkg::OPD_K5:       v = 64'd5;
      bpc_pkg::OPD_K128:     v = 64'd128;
      bpc_pkg::OPD_K128000:  v = 64'd128000;
      bpc_pkg::OPD_K3125:    v = 64'd3125;
      bpc_pkg::OPD_K1048576: v = 64'd1048576;
      bpc_pkg::OPD_K2P47:    v = 64'h0000_8000_0000_0000;
      bpc_pkg::OPD_ZERO:     v = 64'd0;
      default:               v = rd;
    endcase
    return v;
  endfunction

  bpc_ram #(
    .WIDTH(64),
    .DEPTH(bpc_pkg::RegCount)
  ) u_regs (
    .clk(clk),
    .we(we),
    .waddr(cmd.instr.dst),
    .wdata(wdata),
    .raddr_a(cmd.instr.sa[bpc_pkg::RegAw-1:0]),
    .raddr_b(cmd.instr.sb[bpc_pkg::RegAw-1:0]),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign opa = operand(cmd.instr.sa, rdata_a, calib_a_r, calib_b_r, calib_c_r,
                       adct_r, adcp_r);
  assign opb = operand(cmd.instr.sb, rdata_b, calib_a_r, calib_b_r, calib_c_r,
                       adct_r, adcp_r);

  always_comb begin
    case (cmd.instr.op)
      bpc_pkg::OP_ADD: alu_res = opa + opb;
      bpc_pkg::OP_SUB: alu_res = opa - opb;
      bpc_pkg::OP_ASR: alu_res = $signed(opa) >>> cmd.instr.sh;
      bpc_pkg::OP_SHL: alu_res = opa << cmd.instr.sh;
      default:         alu_res = opa;
    endcase
  end

  assign exec_simple = cmd.exec && (cmd.instr.op == bpc_pkg::OP_ADD ||
                                    cmd.instr.op == bpc_pkg::OP_SUB ||
                                    cmd.instr.op == bpc_pkg::OP_ASR ||
                                    cmd.instr.op == bpc_pkg::OP_SHL);
  assign mul_start = cmd.exec && cmd.instr.op == bpc_pkg::OP_MUL;
  assign div_start = cmd.exec && cmd.instr.op == bpc_pkg::OP_DIV;
  assign fin_go = cmd.exec && cmd.instr.op == bpc_pkg::OP_FIN && sts.out_free;

  assign we = exec_simple || mul_done || div_done;
  assign wdata = mul_done ? mul_result : (div_done ? div_result : alu_res);

  assign sts.unit_done = mul_done || div_done;
  assign sts.a_zero = (opa == 64'd0);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Multiplier datapath.
  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mpa = ma_r[31:0];
        mpb = mb_r[31:0];
      end
      2'd1: begin
        mpa = ma_r[31:0];
        mpb = mb_r[63:32];
      end
      default: begin
        mpa = ma_r[63:32];
        mpb = mb_r[31:0];
      end
    endcase
  end
  assign mprod = mpa * mpb;
  assign mul_hi_sum = acc_r[63:32] + mprod[31:0];
  assign mul_done = mul_busy_r && mcnt_r == 2'd2;
  assign mul_result = {mul_hi_sum, acc_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mcnt_r <= '0;
    end else if (mul_start) begin
      mul_busy_r <= 1'b1;
      mcnt_r <= '0;
    end else if (mul_busy_r) begin
      mcnt_r <= mcnt_r + 2'd1;
      if (mcnt_r == 2'd2) begin
        mul_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      ma_r <= opa;
      mb_r <= opb;
    end else if (mul_busy_r) begin
      if (mcnt_r == 2'd0) begin
        acc_r <= mprod;
      end else begin
        acc_r[63:32] <= mul_hi_sum;
      end
    end
  end

  // Divider datapath. The most negative dividend over -1 wraps to itself
  // because magnitudes are handled as unsigned 64-bit values.
  assign dv_trial = {dv_rem_r, dv_q_r[63]};
  assign dv_diff = dv_trial - {1'b0, dv_d_r};
  assign dv_ge = !dv_diff[64];
  assign dv_qn = {dv_q_r[62:0], dv_ge};
  assign div_done = div_busy_r && dv_cnt_r == 6'd63;
  assign div_result = dv_neg_r ? (64'd0 - dv_qn) : dv_qn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      dv_cnt_r <= '0;
    end else if (div_start) begin
      div_busy_r <= 1'b1;
      dv_cnt_r <= '0;
    end else if (div_busy_r) begin
      dv_cnt_r <= dv_cnt_r + 6'd1;
      if (dv_cnt_r == 6'd63) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dv_rem_r <= '0;
      dv_q_r <= opa[63] ? (64'd0 - opa) : opa;
      dv_d_r <= opb[63] ? (64'd0 - opb) : opb;
      dv_neg_r <= opa[63] ^ opb[63];
    end else if (div_busy_r) begin
      dv_rem_r <= dv_ge ? dv_diff[63:0] : dv_trial[63:0];
      dv_q_r <= dv_qn;
    end
  end

  // Saturate the final pressure to the unsigned 32-bit range.
  always_comb begin
    if (opb[63]) begin
      pres_sat = 32'd0;
    end else if (opb[63:32] != 32'd0) begin
      pres_sat = 32'hFFFF_FFFF;
    end else begin
      pres_sat = opb[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_a_r <= '0;
      calib_b_r <= '0;
      calib_c_r <= '0;
      last_r <= '0;
      held_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgA: calib_a_r <= cfg_data;
          CfgB: calib_b_r <= cfg_data;
          CfgC: calib_c_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        held_r <= 1'b0;
      end else if (cmd.exec && cmd.instr.op == bpc_pkg::OP_CHK) begin
        held_r <= sts.a_zero;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (!held_r) begin
          last_r <= pres_sat;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adct_r <= in_raw_temperature;
      adcp_r <= in_raw_pressure;
    end
    if (fin_go) begin
      out_temp_r <= opa[31:0];
      out_pres_r <= held_r ? last_r : pres_sat;
      out_held_r <= held_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_q24_8 = out_pres_r;
  assign out_pressure_held = out_held_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy_r && div_busy_r))
    else $error("multiplier and divider busy together");

  a_last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pres_r == last_r)
    else $error("shown pressure differs from stored last pressure");

endmodule

// ===== hdl/baro_pressure_temp_compensation_core.sv =====
// Top level of the barometric temperature and pressure compensation core.
`timescale 1ns / 1ps
// Each transfer on the input channel carries one raw temperature and one raw
// pressure reading; the core runs a fixed microprogram of 64-bit integer steps
// on one shared 32x32 multiplier and a bit-serial divider and returns one result
// transfer per input. Every instruction passes a fetch state for its scratch RAM
// read, a multiply then waits on the multiplier and the signed 64-bit division
// on the divider; a zero pressure divisor skips the pressure steps. One item is
// worked on at a time; the next is taken in the cycle after the result has moved
// to the output register, which a stalled output can delay.
// Calibration registers are written through the cfg port, which is always ready
// and must be used only while the core is idle.
module baro_pressure_temp_compensation_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_pressure_held
);

  bpc_pkg::ctrl_cmd_t  cmd;
  bpc_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  bpc_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  bpc_datapath u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_raw_temperature(in_raw_temperature),
    .in_raw_pressure(in_raw_pressure),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_q24_8(out_pressure_q24_8),
    .out_pressure_held(out_pressure_held)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the barometric temperature and pressure compensation core.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] IDX_CALIB_A = 2'd0;
  localparam logic [1:0] IDX_CALIB_B = 2'd1;
  localparam logic [1:0] IDX_CALIB_C = 2'd2;
  localparam logic [1:0] IDX_UNUSED  = 2'd3;
  localparam logic [63:0] CALIB_A_TYP = {16'd36477, -16'sd1000, 16'd26435, 16'd27504};
  localparam logic [63:0] CALIB_B_TYP = {16'd140, 16'd2855, 16'd3024, -16'sd10685};
  localparam logic [63:0] CALIB_C_TYP = {16'd6000, -16'sd14600, 16'd15500, -16'sd7};
  localparam int DRAIN_CYCLES = 260;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } reading_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        held;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_temperature_centi;
  logic [31:0] out_pressure_q24_8;
  logic out_pressure_held;

  baro_pressure_temp_compensation_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  reading_t pending_readings[$];
  comp_result_t expected_results[$];
  logic [63:0] calib_a = '0, calib_b = '0, calib_c = '0;
  logic [31:0] last_press = '0;
  int errors = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  logic in_taken = 1'b0;

  function automatic logic [63:0] asr(logic [63:0] x, int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] sext(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Truncating signed division; the most negative value over -1 wraps to itself.
  function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(reading_t rd);
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] adc_t, adc_p, d1, d2, tf, a, b, q, s, c1, c2;
    comp_result_t r;
    t1 = {48'd0, calib_a[15:0]};
    t2 = sext(calib_a[31:16]);
    t3 = sext(calib_a[47:32]);
    p1 = {48'd0, calib_a[63:48]};
    p2 = sext(calib_b[15:0]);
    p3 = sext(calib_b[31:16]);
    p4 = sext(calib_b[47:32]);
    p5 = sext(calib_b[63:48]);
    p6 = sext(calib_c[15:0]);
    p7 = sext(calib_c[31:16]);
    p8 = sext(calib_c[47:32]);
    p9 = sext(calib_c[63:48]);
    adc_t = {44'd0, rd.raw_t};
    adc_p = {44'd0, rd.raw_p};
    d1 = (adc_t >> 3) - (t1 << 1);
    d2 = (adc_t >> 4) - t1;
    tf = asr(d1 * t2, 11) + asr(asr(d2 * d2, 12) * t3, 14);
    r.temp = 32'(asr(tf * 64'd5 + 64'd128, 8));
    a = tf - 64'd128000;
    b = a * a * p6 + ((a * p5) << 17) + (p4 << 35);
    a = asr(a * a * p3, 8) + ((a * p2) << 12);
    a = asr(((64'd1 << 47) + a) * p1, 33);
    if (a == 64'd0) begin
      r.press = last_press;
      r.held = 1'b1;
    end else begin
      q = 64'd1048576 - adc_p;
      q = sdiv(((q << 31) - b) * 64'd3125, a);
      s = asr(q, 13);
      c1 = asr(p9 * s * s, 25);
      c2 = asr(p8 * q, 19);
      q = asr(q + c1 + c2, 8) + (p7 << 4);
      if (q[63]) r.press = 32'd0;
      else if (q > 64'hFFFF_FFFF) r.press = 32'hFFFF_FFFF;
      else r.press = q[31:0];
      last_press = r.press;
      r.held = 1'b0;
    end
    return r;
  endfunction

  // Input transfers are predicted here; result transfers are checked in order.
  always @(posedge clk) begin
    comp_result_t got, exp_r;
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(compensate({in_raw_temperature, in_raw_pressure}));
    if (rst_n && out_valid && !out_stall) begin
      got = {out_temperature_centi, out_pressure_q24_8, out_pressure_held};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.temp !== exp_r.temp) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   $signed(exp_r.temp), $signed(got.temp));
          errors++;
        end
        if (got.press !== exp_r.press) begin
          $display("%0t: pressure expected %h actual %h", $time, exp_r.press, got.press);
          errors++;
        end
        if (got.held !== exp_r.held) begin
          $display("%0t: held flag expected %b actual %b", $time, exp_r.held, got.held);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    reading_t rd;
    if (!in_valid || in_taken) begin
      if (rst_n && pending_readings.size() > 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
        rd = pending_readings.pop_front();
        in_raw_temperature <= rd.raw_t;
        in_raw_pressure <= rd.raw_p;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver's long hold-off is counted here so the core backs up into its input.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req <= hold_req - 1;
    end else begin
      out_stall <= !quiet && $urandom_range(0, 99) < 18;
    end
  end

  task automatic write_calib(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      IDX_CALIB_A: calib_a = data;
      IDX_CALIB_B: calib_b = data;
      IDX_CALIB_C: calib_c = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_reading(logic [19:0] rt, logic [19:0] rp);
    pending_readings.push_back({rt, rp});
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7)
        add_reading(20'(519888 + $urandom_range(0, 60000) - 30000),
                    20'(415148 + $urandom_range(0, 300000) - 150000));
      else
        add_reading(20'($urandom), 20'($urandom));
    end
  endtask

  task automatic drain();
    while (pending_readings.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_extremes();
    add_reading(20'd0, 20'd0);
    add_reading(20'hFFFFF, 20'hFFFFF);
    add_reading(20'd0, 20'hFFFFF);
    add_reading(20'hFFFFF, 20'd0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Calibration at reset: zero divisor, so pressure repeats zero.
    add_extremes();
    add_reading(20'd519888, 20'd415148);
    drain();

    write_calib(IDX_CALIB_A, CALIB_A_TYP);
    write_calib(IDX_CALIB_B, CALIB_B_TYP);
    write_calib(IDX_CALIB_C, CALIB_C_TYP);
    add_extremes();
    add_reading(20'd519888, 20'd415148);
    add_reading(20'd519888, 20'd1);
    hold_req = 900;
    add_random(190);
    drain();

    write_calib(IDX_CALIB_A, {$urandom, $urandom});
    write_calib(IDX_CALIB_B, {$urandom, $urandom});
    write_calib(IDX_CALIB_C, {$urandom, $urandom});
    add_random(100);
    drain();

    write_calib(IDX_CALIB_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_calib(IDX_CALIB_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_calib(IDX_CALIB_C, 64'hFFFF_FFFF_FFFF_FFFF);
    add_extremes();
    add_random(15);
    drain();
    write_calib(IDX_CALIB_A, 64'h8000_8000_8000_8000);
    write_calib(IDX_CALIB_B, 64'h7FFF_8000_7FFF_8000);
    write_calib(IDX_CALIB_C, 64'h8000_7FFF_8000_7FFF);
    // A write to the unused index must leave the calibration alone.
    write_calib(IDX_UNUSED, {$urandom, $urandom});
    add_extremes();
    add_random(15);
    drain();

    write_calib(IDX_CALIB_A, CALIB_A_TYP);
    write_calib(IDX_CALIB_B, CALIB_B_TYP);
    write_calib(IDX_CALIB_C, CALIB_C_TYP);
    quiet = 1'b1;
    add_random(100);
    drain();
    quiet = 1'b0;

    // Zero p1 makes the divisor zero after a real pressure has been stored.
    write_calib(IDX_CALIB_A, {16'd0, CALIB_A_TYP[47:0]});
    add_extremes();
    add_random(8);
    drain();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== baro_pressure_temp_compensation_core.f =====
hdl/bpc_pkg.sv
hdl/bpc_ram.sv
hdl/bpc_ctrl.sv
hdl/bpc_datapath.sv
hdl/baro_pressure_temp_compensation_core.sv
tb/tb_top.sv
